/* rtl/bdc_pkg.sv */
// Shared types and constants for the base-2^b digit extractor with checksum.
// Holds the register map, reset values and the configuration struct.
// No dependencies.
`default_nettype none

package bdc_pkg;

	// Configuration port geometry.
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	// Output digit width and checksum limits.
	localparam int unsigned DIGIT_W   = 16;
	localparam int unsigned CHK_MAX   = 16;
	localparam int unsigned CHK_CNT_W = 4;

	// Register indexes, one word apart on the configuration port.
	typedef enum logic [2:0] {
		REG_DIGIT_BITS      = 3'd0,
		REG_MESSAGE_DIGITS  = 3'd1,
		REG_CHECKSUM_DIGITS = 3'd2,
		REG_SUM_TARGET      = 3'd3,
		REG_SUM_MODE        = 3'd4
	} reg_idx_t;

	// Reset values of the registers.
	localparam logic [4:0]  RST_DIGIT_BITS      = 5'd4;
	localparam logic [8:0]  RST_MESSAGE_DIGITS  = 9'd32;
	localparam logic [4:0]  RST_CHECKSUM_DIGITS = 5'd3;
	localparam logic [23:0] RST_SUM_TARGET      = 24'd480;
	localparam logic        RST_SUM_MODE        = 1'b0;

	// Register contents as written.
	typedef struct packed {
		logic [4:0]  digit_bits;
		logic [8:0]  message_digits;
		logic [4:0]  checksum_digits;
		logic [23:0] sum_target;
		logic        sum_mode;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/bdc_cfg.sv */
// Register file behind the APB-style configuration port.
// Depends on bdc_pkg for the register map and reset values.
`default_nettype none

module bdc_cfg
	import bdc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg,
	output logic                   bits_wr
);

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// A write of the digit width tells the datapath to drop its held bits.
	assign bits_wr = wr_en && (idx == REG_DIGIT_BITS);

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.digit_bits      <= RST_DIGIT_BITS;
			cfg_q.message_digits  <= RST_MESSAGE_DIGITS;
			cfg_q.checksum_digits <= RST_CHECKSUM_DIGITS;
			cfg_q.sum_target      <= RST_SUM_TARGET;
			cfg_q.sum_mode        <= RST_SUM_MODE;
		end else if (wr_en) begin
			unique case (idx)
				REG_DIGIT_BITS:      cfg_q.digit_bits      <= pwdata[4:0];
				REG_MESSAGE_DIGITS:  cfg_q.message_digits  <= pwdata[8:0];
				REG_CHECKSUM_DIGITS: cfg_q.checksum_digits <= pwdata[4:0];
				REG_SUM_TARGET:      cfg_q.sum_target      <= pwdata[23:0];
				REG_SUM_MODE:        cfg_q.sum_mode        <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read-back mux.
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_DIGIT_BITS:      prdata = DATA_W'(cfg_q.digit_bits);
			REG_MESSAGE_DIGITS:  prdata = DATA_W'(cfg_q.message_digits);
			REG_CHECKSUM_DIGITS: prdata = DATA_W'(cfg_q.checksum_digits);
			REG_SUM_TARGET:      prdata = DATA_W'(cfg_q.sum_target);
			REG_SUM_MODE:        prdata = DATA_W'(cfg_q.sum_mode);
			default:             prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/bdc_digit.sv */
// Bit accumulator, digit extractor, running sum and checksum emitter.
// Depends on bdc_pkg for the configuration struct and field widths.
`default_nettype none

module bdc_digit
	import bdc_pkg::*;
#(
	parameter int unsigned MAX_DIGIT_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire cfg_t                              cfg,
	input  wire logic                              bits_wr,
	input  wire logic [$clog2(MAX_DIGIT_BITS+1)-1:0] eff_b,
	input  wire logic [8:0]                        msg_len,
	input  wire logic [4:0]                        chk_len,
	input  wire logic                              msg_valid,
	output logic                                   msg_stall,
	input  wire logic [7:0]                        msg_byte,
	output logic                                   digit_valid,
	input  wire logic                              digit_stall,
	output logic [DIGIT_W-1:0]                     digit,
	output logic                                   is_checksum,
	output logic                                   last_digit,
	output logic                                   sum_ok
);

	localparam int unsigned BUF_W  = MAX_DIGIT_BITS + 8;
	localparam int unsigned HELD_W = $clog2(MAX_DIGIT_BITS + 8);
	localparam int unsigned SH_W   = $clog2(MAX_DIGIT_BITS * (CHK_MAX - 1) + 1);

	// Message state.
	logic [BUF_W-1:0]     buf_q;
	logic [HELD_W-1:0]    held_q;
	logic [8:0]           done_q;
	logic [31:0]          sum_q;
	// Checksum state.
	logic                 chk_q;
	logic [CHK_CNT_W-1:0] cnt_q;
	logic [31:0]          csum_q;
	// Result register.
	logic                 out_valid_q;
	logic [DIGIT_W-1:0]   digit_q;
	logic                 is_chk_q;
	logic                 last_q;
	logic                 ok_q;

	logic [HELD_W-1:0]         b_ext;
	logic                      take;
	logic [BUF_W-1:0]          wb;
	logic [HELD_W-1:0]         wh;
	logic [HELD_W-1:0]         rem;
	logic [MAX_DIGIT_BITS-1:0] d;
	logic                      room;
	logic                      has_digit;
	logic [8:0]                new_done;
	logic                      msg_end;
	logic [31:0]               new_sum;
	logic [31:0]               csum;
	logic [SH_W-1:0]           sh;
	logic [31:0]               mask_b;
	logic [31:0]               cdig;

	assign b_ext = HELD_W'(eff_b);

	// A byte is taken only once every digit of the held bits has left and no checksum is due.
	assign msg_stall = chk_q || (held_q >= b_ext);
	assign take      = msg_valid && !msg_stall;

	// Working buffer: held bits with the incoming byte appended below them.
	assign wb = take ? {buf_q[BUF_W-9:0], msg_byte} : buf_q;
	assign wh = take ? held_q + HELD_W'(8) : held_q;

	// Top b bits of the working buffer form the next message digit.
	assign rem       = wh - b_ext;
	assign d         = MAX_DIGIT_BITS'(wb >> rem);
	assign room      = !out_valid_q || !digit_stall;
	assign has_digit = !chk_q && (wh >= b_ext);

	assign new_done = done_q + 9'd1;
	assign msg_end  = !(new_done < msg_len);
	assign new_sum  = sum_q + 32'(d);
	assign csum     = 32'(cfg.sum_target) - new_sum;

	// Checksum digit: remaining count times b gives the shift.
	assign sh     = SH_W'(eff_b) * SH_W'(cnt_q);
	assign mask_b = 32'((33'd1 << eff_b) - 33'd1);
	assign cdig   = (sh >= SH_W'(32)) ? 32'd0 : ((csum_q >> sh) & mask_b);

	// Digit engine and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q       <= '0;
			held_q      <= '0;
			done_q      <= '0;
			sum_q       <= '0;
			chk_q       <= 1'b0;
			cnt_q       <= '0;
			csum_q      <= '0;
			out_valid_q <= 1'b0;
			digit_q     <= '0;
			is_chk_q    <= 1'b0;
			last_q      <= 1'b0;
			ok_q        <= 1'b0;
		end else begin
			if (room) begin
				out_valid_q <= 1'b0;
			end
			if (bits_wr) begin
				buf_q  <= '0;
				held_q <= '0;
			end else if (chk_q) begin
				if (room) begin
					out_valid_q <= 1'b1;
					digit_q     <= cdig[DIGIT_W-1:0];
					is_chk_q    <= 1'b1;
					last_q      <= (cnt_q == '0);
					ok_q        <= 1'b0;
					cnt_q       <= cnt_q - CHK_CNT_W'(1);
					if (cnt_q == '0) begin
						chk_q <= 1'b0;
					end
				end
			end else if (has_digit && room) begin
				out_valid_q <= 1'b1;
				digit_q     <= DIGIT_W'(d);
				is_chk_q    <= 1'b0;
				if (msg_end) begin
					// End of message: drop leftover bits and start afresh.
					last_q <= cfg.sum_mode || (chk_len == 5'd0);
					ok_q   <= cfg.sum_mode && (new_sum == 32'(cfg.sum_target));
					buf_q  <= '0;
					held_q <= '0;
					done_q <= '0;
					sum_q  <= '0;
					if (!cfg.sum_mode && (chk_len != 5'd0)) begin
						chk_q  <= 1'b1;
						cnt_q  <= CHK_CNT_W'(chk_len - 5'd1);
						csum_q <= csum;
					end
				end else begin
					last_q <= 1'b0;
					ok_q   <= 1'b0;
					buf_q  <= wb & ((BUF_W'(1) << rem) - BUF_W'(1));
					held_q <= rem;
					done_q <= new_done;
					sum_q  <= new_sum;
				end
			end else begin
				// Absorb the byte while the result register is full or too few bits are held.
				buf_q  <= wb;
				held_q <= wh;
			end
		end
	end

	assign digit_valid = out_valid_q;
	assign digit       = digit_q;
	assign is_checksum = is_chk_q;
	assign last_digit  = last_q;
	assign sum_ok      = ok_q;

endmodule

`default_nettype wire

/* rtl/base_2b_digits_with_checksum.sv */
// Top level of the base-2^b digit extractor with checksum or constant-sum check.
// Depends on bdc_pkg, bdc_cfg and bdc_digit.
//
// Message bytes arrive on the msg channel, most significant bit first, and leave as
// b-bit digits on the digit channel, one digit per clock cycle at most. A byte is
// taken once fewer than b bits are held, and a digit may be produced from it in the
// same cycle; a digit is produced only while the single result register has room.
// At the end of a message in checksum mode the checksum digits follow, one per
// cycle while the digit channel does not stall, and no byte is taken. The user must
// write configuration over the APB-style port only while the block is idle; the
// block does not enforce this. Writing the digit width drops any held bits.
`default_nettype none

module base_2b_digits_with_checksum
	import bdc_pkg::*;
#(
	parameter int unsigned MAX_DIGIT_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	input  wire logic              msg_valid,
	output logic                   msg_stall,
	input  wire logic [7:0]        msg_byte,
	output logic                   digit_valid,
	input  wire logic              digit_stall,
	output logic [DIGIT_W-1:0]     digit,
	output logic                   is_checksum,
	output logic                   last_digit,
	output logic                   sum_ok
);

	localparam int unsigned B_W = $clog2(MAX_DIGIT_BITS + 1);

	cfg_t           cfg;
	logic           bits_wr;
	logic [B_W-1:0] eff_b;
	logic [8:0]     msg_len;
	logic [4:0]     chk_len;

	bdc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.bits_wr (bits_wr)
	);

	// Clamp the register values into their working ranges.
	always_comb begin
		if (cfg.digit_bits == 5'd0) begin
			eff_b = B_W'(1);
		end else if (6'(cfg.digit_bits) > 6'(MAX_DIGIT_BITS)) begin
			eff_b = B_W'(MAX_DIGIT_BITS);
		end else begin
			eff_b = B_W'(cfg.digit_bits);
		end
		msg_len = (cfg.message_digits == 9'd0) ? 9'd1 : cfg.message_digits;
		chk_len = (cfg.checksum_digits > 5'(CHK_MAX)) ? 5'(CHK_MAX) : cfg.checksum_digits;
	end

	bdc_digit #(
		.MAX_DIGIT_BITS (MAX_DIGIT_BITS)
	) u_digit (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.bits_wr     (bits_wr),
		.eff_b       (eff_b),
		.msg_len     (msg_len),
		.chk_len     (chk_len),
		.msg_valid   (msg_valid),
		.msg_stall   (msg_stall),
		.msg_byte    (msg_byte),
		.digit_valid (digit_valid),
		.digit_stall (digit_stall),
		.digit       (digit),
		.is_checksum (is_checksum),
		.last_digit  (last_digit),
		.sum_ok      (sum_ok)
	);

endmodule

`default_nettype wire
